@@ hdl/saa_pkg.sv @@
// Shared constants, types and helpers for the skyline atlas allocator.
package saa_pkg;

  localparam int ATLAS_WIDTH  = 1024;
  localparam int ATLAS_HEIGHT = 1024;
  localparam int MAX_PAGES    = 256;
  localparam int GROW_STEP    = 2;

  // Fixed field widths of the ports.
  localparam int RECT_W  = 11;
  localparam int PLACE_W = 10;
  localparam int PAGE_W  = 8;
  localparam int CFG_W   = 9;

  // Internal widths follow the atlas geometry.
  localparam int COL_W  = $clog2(ATLAS_WIDTH);
  localparam int HGT_W  = $clog2(ATLAS_HEIGHT + 1);
  localparam int PIDX_W = $clog2(MAX_PAGES);
  localparam int PCNT_W = $clog2(MAX_PAGES + 1);

  typedef logic [COL_W-1:0]  col_t;
  typedef logic [HGT_W-1:0]  hgt_t;
  typedef logic [PIDX_W-1:0] pidx_t;
  typedef logic [PCNT_W-1:0] pcnt_t;

  // A written page count is held within one and the page limit.
  function automatic pcnt_t clamp_pages(logic [CFG_W-1:0] v);
    pcnt_t res;
    if (v == '0) begin
      res = PCNT_W'(1);
    end else if (32'(v) > 32'(MAX_PAGES)) begin
      res = PCNT_W'(MAX_PAGES);
    end else begin
      res = PCNT_W'(v);
    end
    return res;
  endfunction

endpackage

@@ hdl/saa_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module saa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/skyline_atlas_allocator.sv @@
// Skyline atlas allocator: lowest-window search over a column height memory.
//
//   channel  direction  handshake           beat
//   cfg      in         cfg_wr_en           initial page count
//   in       in         in_valid/in_ready   rectangle width and height
//   out      out        out_valid/out_ready placement, page, status, grow flag
//
// A request that fits is handled in passes: a forward pass over the skyline memory
// builds block prefix maxima, a backward pass forms each window maximum, and a
// write pass raises the chosen columns. A page advance replaces the write
// pass with a clearing sweep that also raises the new rectangle's columns.
// Too-large and zero-width requests go from idle straight to the result state.
// After reset the whole skyline memory is cleared, and in_ready is low
// until then. A result waiting on out_ready does not stop the next beat entering.
module skyline_atlas_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [saa_pkg::CFG_W-1:0]    cfg_initial_pages,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [saa_pkg::RECT_W-1:0]   in_rect_width,
  input  logic [saa_pkg::RECT_W-1:0]   in_rect_height,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [saa_pkg::PLACE_W-1:0]  out_place_x,
  output logic [saa_pkg::PLACE_W-1:0]  out_place_y,
  output logic [saa_pkg::PAGE_W-1:0]   out_page_index,
  output logic                         out_status,
  output logic                         out_grow_request
);

  import saa_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_FWD, S_BWD, S_DRAIN, S_DECIDE, S_WRITE, S_RESULT
  } state_t;

  localparam col_t COL_LAST = COL_W'(ATLAS_WIDTH - 1);

  // Control registers
  state_t state_r, state_nxt;
  col_t   c_r, c_nxt;
  col_t   k_r, k_nxt;
  logic   p1_vld_r, p1_vld_nxt;
  logic   clr_item_r, clr_item_nxt;
  pidx_t  cur_r, cur_nxt;
  pcnt_t  pcnt_r, pcnt_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Payload registers
  col_t   w_r, w_nxt;
  hgt_t   h_r, h_nxt;
  hgt_t   top_r, top_nxt;
  hgt_t   best_r, best_nxt;
  col_t   bx_r, bx_nxt;
  hgt_t   pmax_r, pmax_nxt;
  hgt_t   smax_r, smax_nxt;
  logic   p1_bwd_r, p1_bwd_nxt;
  col_t   p1_col_r, p1_col_nxt;
  logic   p1_first_r, p1_first_nxt;
  logic   p1_ok_r, p1_ok_nxt;
  logic [PLACE_W-1:0] res_x_r, res_x_nxt, res_y_r, res_y_nxt;
  logic [PAGE_W-1:0]  res_pg_r, res_pg_nxt;
  logic   res_st_r, res_st_nxt;
  logic   res_gr_r, res_gr_nxt;
  logic [PLACE_W-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic [PAGE_W-1:0]  out_pg_r, out_pg_nxt;
  logic   out_st_r, out_st_nxt;
  logic   out_gr_r, out_gr_nxt;

  // Memory ports
  logic sky_we;
  col_t sky_waddr, sky_raddr;
  hgt_t sky_wdata, sky_rdata;
  logic pre_we;
  col_t pre_waddr, pre_raddr;
  hgt_t pre_wdata, pre_rdata;

  // Combinational helpers
  col_t               wm1;
  logic               too_big;
  hgt_t               run_max, win_max;
  logic [HGT_W:0]     fit_sum;
  logic [PCNT_W:0]    pg_inc;
  logic [PCNT_W:0]    grown;

  saa_ram #(.WIDTH(HGT_W), .DEPTH(ATLAS_WIDTH)) u_sky_ram (
    .clk   (clk),
    .we    (sky_we),
    .waddr (sky_waddr),
    .wdata (sky_wdata),
    .raddr (sky_raddr),
    .rdata (sky_rdata)
  );

  // Holds the running maximum from each block start, blocks being rect_width wide.
  saa_ram #(.WIDTH(HGT_W), .DEPTH(ATLAS_WIDTH)) u_pre_ram (
    .clk   (clk),
    .we    (pre_we),
    .waddr (pre_waddr),
    .wdata (pre_wdata),
    .raddr (pre_raddr),
    .rdata (pre_rdata)
  );

  assign wm1     = w_r - col_t'(1);
  assign too_big = (32'(in_rect_width) >= 32'(ATLAS_WIDTH)) ||
                   (32'(in_rect_height) > 32'(ATLAS_HEIGHT));
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    c_nxt         = c_r;
    k_nxt         = k_r;
    p1_vld_nxt    = 1'b0;
    clr_item_nxt  = clr_item_r;
    cur_nxt       = cur_r;
    pcnt_nxt      = pcnt_r;
    out_valid_nxt = out_valid_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    top_nxt       = top_r;
    best_nxt      = best_r;
    bx_nxt        = bx_r;
    pmax_nxt      = pmax_r;
    smax_nxt      = smax_r;
    p1_bwd_nxt    = p1_bwd_r;
    p1_col_nxt    = p1_col_r;
    p1_first_nxt  = p1_first_r;
    p1_ok_nxt     = p1_ok_r;
    res_x_nxt     = res_x_r;
    res_y_nxt     = res_y_r;
    res_pg_nxt    = res_pg_r;
    res_st_nxt    = res_st_r;
    res_gr_nxt    = res_gr_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_pg_nxt    = out_pg_r;
    out_st_nxt    = out_st_r;
    out_gr_nxt    = out_gr_r;
    sky_we        = 1'b0;
    sky_waddr     = c_r;
    sky_wdata     = top_r;
    sky_raddr     = c_r;
    pre_we        = 1'b0;
    pre_waddr     = p1_col_r;
    pre_wdata     = '0;
    pre_raddr     = c_r + wm1;
    run_max       = '0;
    win_max       = '0;
    fit_sum       = {1'b0, best_r} + {1'b0, h_r};
    pg_inc        = (PCNT_W+1)'(cur_r) + (PCNT_W+1)'(1);
    grown         = (PCNT_W+1)'(pcnt_r);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // Data stage: works in the cycle after the read is issued.
    if (p1_vld_r) begin
      if (!p1_bwd_r) begin
        run_max   = (p1_first_r || sky_rdata > pmax_r) ? sky_rdata : pmax_r;
        pmax_nxt  = run_max;
        pre_we    = 1'b1;
        pre_wdata = run_max;
      end else begin
        run_max  = (p1_first_r || sky_rdata > smax_r) ? sky_rdata : smax_r;
        smax_nxt = run_max;
        win_max  = (pre_rdata > run_max) ? pre_rdata : run_max;
        // Scanning backwards, ties move the pick to the earlier start column.
        if (p1_ok_r && (32'(win_max) < 32'(ATLAS_HEIGHT)) && (win_max <= best_r)) begin
          best_nxt = win_max;
          bx_nxt   = p1_col_r;
        end
      end
    end

    case (state_r)
      S_CLEAR: begin
        sky_we    = 1'b1;
        sky_wdata = (clr_item_r && (c_r < w_r)) ? top_r : '0;
        c_nxt     = c_r + col_t'(1);
        if (c_r == COL_LAST) begin
          clr_item_nxt = 1'b0;
          state_nxt    = clr_item_r ? S_RESULT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (too_big) begin
            res_x_nxt  = '0;
            res_y_nxt  = '0;
            res_pg_nxt = '0;
            res_st_nxt = 1'b1;
            res_gr_nxt = 1'b0;
            state_nxt  = S_RESULT;
          end else if (in_rect_width == '0) begin
            // Every start column qualifies; the last column is reported, at row 0.
            res_x_nxt  = PLACE_W'(ATLAS_WIDTH - 1);
            res_y_nxt  = '0;
            res_pg_nxt = PAGE_W'(cur_r);
            res_st_nxt = 1'b0;
            res_gr_nxt = 1'b0;
            state_nxt  = S_RESULT;
          end else begin
            w_nxt     = COL_W'(in_rect_width);
            h_nxt     = HGT_W'(in_rect_height);
            c_nxt     = '0;
            k_nxt     = '0;
            best_nxt  = HGT_W'(ATLAS_HEIGHT);
            bx_nxt    = '0;
            state_nxt = S_FWD;
          end
        end
      end
      S_FWD: begin
        p1_vld_nxt   = 1'b1;
        p1_bwd_nxt   = 1'b0;
        p1_col_nxt   = c_r;
        p1_first_nxt = (k_r == '0);
        if (c_r == COL_LAST) begin
          // k_r now holds the block offset of the last column for the way back.
          state_nxt = S_BWD;
        end else begin
          c_nxt = c_r + col_t'(1);
          k_nxt = (k_r == wm1) ? '0 : k_r + col_t'(1);
        end
      end
      S_BWD: begin
        p1_vld_nxt   = 1'b1;
        p1_bwd_nxt   = 1'b1;
        p1_col_nxt   = c_r;
        p1_first_nxt = (c_r == COL_LAST) || (k_r == wm1);
        p1_ok_nxt    = ({1'b0, c_r} + {1'b0, w_r}) < (COL_W+1)'(ATLAS_WIDTH);
        c_nxt        = c_r - col_t'(1);
        k_nxt        = (k_r == '0) ? wm1 : k_r - col_t'(1);
        if (c_r == '0) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (32'(fit_sum) <= 32'(ATLAS_HEIGHT)) begin
          res_x_nxt  = PLACE_W'(bx_r);
          res_y_nxt  = PLACE_W'(best_r);
          res_pg_nxt = PAGE_W'(cur_r);
          res_st_nxt = 1'b0;
          res_gr_nxt = 1'b0;
          top_nxt    = HGT_W'(fit_sum);
          c_nxt      = bx_r;
          k_nxt      = w_r;
          state_nxt  = S_WRITE;
        end else begin
          // New page: the first window of a cleared skyline sits at column 0, row 0.
          if (32'(pg_inc) >= 32'(MAX_PAGES)) begin
            pg_inc = '0;
          end
          cur_nxt = PIDX_W'(pg_inc);
          res_gr_nxt = 1'b0;
          if (pg_inc >= (PCNT_W+1)'(pcnt_r)) begin
            grown = (PCNT_W+1)'(pcnt_r) + (PCNT_W+1)'(GROW_STEP);
            if (32'(grown) > 32'(MAX_PAGES)) begin
              grown = (PCNT_W+1)'(MAX_PAGES);
            end
            res_gr_nxt = (grown > (PCNT_W+1)'(pcnt_r));
            pcnt_nxt   = PCNT_W'(grown);
          end
          res_x_nxt    = '0;
          res_y_nxt    = '0;
          res_pg_nxt   = PAGE_W'(pg_inc);
          res_st_nxt   = 1'b0;
          top_nxt      = h_r;
          clr_item_nxt = 1'b1;
          c_nxt        = '0;
          state_nxt    = S_CLEAR;
        end
      end
      S_WRITE: begin
        sky_we = 1'b1;
        c_nxt  = c_r + col_t'(1);
        k_nxt  = k_r - col_t'(1);
        if (k_r == col_t'(1)) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_x_nxt     = res_x_r;
          out_y_nxt     = res_y_r;
          out_pg_nxt    = res_pg_r;
          out_st_nxt    = res_st_r;
          out_gr_nxt    = res_gr_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_wr_en) begin
      pcnt_nxt = clamp_pages(cfg_initial_pages);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      c_r         <= '0;
      k_r         <= '0;
      p1_vld_r    <= 1'b0;
      clr_item_r  <= 1'b0;
      cur_r       <= '0;
      pcnt_r      <= PCNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      c_r         <= c_nxt;
      k_r         <= k_nxt;
      p1_vld_r    <= p1_vld_nxt;
      clr_item_r  <= clr_item_nxt;
      cur_r       <= cur_nxt;
      pcnt_r      <= pcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r        <= w_nxt;
    h_r        <= h_nxt;
    top_r      <= top_nxt;
    best_r     <= best_nxt;
    bx_r       <= bx_nxt;
    pmax_r     <= pmax_nxt;
    smax_r     <= smax_nxt;
    p1_bwd_r   <= p1_bwd_nxt;
    p1_col_r   <= p1_col_nxt;
    p1_first_r <= p1_first_nxt;
    p1_ok_r    <= p1_ok_nxt;
    res_x_r    <= res_x_nxt;
    res_y_r    <= res_y_nxt;
    res_pg_r   <= res_pg_nxt;
    res_st_r   <= res_st_nxt;
    res_gr_r   <= res_gr_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_pg_r   <= out_pg_nxt;
    out_st_r   <= out_st_nxt;
    out_gr_r   <= out_gr_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_place_x      = out_x_r;
  assign out_place_y      = out_y_r;
  assign out_page_index   = out_pg_r;
  assign out_status       = out_st_r;
  assign out_grow_request = out_gr_r;

endmodule
